/* design/npr_pkg.sv */
// Package for the nearest palette color remap unit.
// Holds the command and status bundles between controller and datapath, and fixed widths.
// Depends on nothing; every other design file refers to it by scoped names.
package npr_pkg;

   localparam int unsigned COLOR_W = 8;
   localparam int unsigned QUERY_W = 6;
   localparam int unsigned SIZE_W  = 9;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned SQ_W    = 2 * COLOR_W;
   // Three squared 8-bit differences sum to at most 195075, which fits 18 bits.
   localparam int unsigned DIST_W  = SQ_W + 2;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
   localparam logic              MODE_LOAD  = 1'b0;
   localparam logic              MODE_REMAP = 1'b1;

   typedef struct packed {
      logic load;      // write the accepted beat into the palette store
      logic start;     // capture the query and clear the running best
      logic issue;     // read the next palette entry and advance the address
      logic load_out;  // copy the best index into the result register
   } cmd_type;

   typedef struct packed {
      logic is_load;    // the offered request beat is a palette load
      logic skip;       // the offered remap needs no search and maps to zero
      logic last_issue; // the current address is the last one to search
      logic pipe_busy;  // a read or a distance is still in flight
   } status_type;

endpackage

/* design/npr_req_if.sv */
// Request channel interface of the nearest palette color remap unit.
// Carries valid, ready and one load or remap beat; widths come from npr_pkg.
interface npr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [npr_pkg::INDEX_W-1:0]   entry_index;
   logic [npr_pkg::COLOR_W-1:0]   entry_red;
   logic [npr_pkg::COLOR_W-1:0]   entry_green;
   logic [npr_pkg::COLOR_W-1:0]   entry_blue;
   logic [npr_pkg::QUERY_W-1:0]   query_red;
   logic [npr_pkg::QUERY_W-1:0]   query_green;
   logic [npr_pkg::QUERY_W-1:0]   query_blue;
   logic [npr_pkg::INDEX_W-1:0]   map_position;

   modport source (
      output valid, mode, entry_index, entry_red, entry_green, entry_blue,
             query_red, query_green, query_blue, map_position,
      input  ready
   );
   modport sink (
      input  valid, mode, entry_index, entry_red, entry_green, entry_blue,
             query_red, query_green, query_blue, map_position,
      output ready
   );
endinterface

/* design/npr_rsp_if.sv */
// Result channel interface of the nearest palette color remap unit.
// Carries valid, ready and the mapped index; widths come from npr_pkg.
interface npr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [npr_pkg::INDEX_W-1:0] mapped_index;

   modport source (output valid, mapped_index, input ready);
   modport sink (input valid, mapped_index, output ready);
endinterface

/* design/npr_datapath.sv */
// Datapath of the nearest palette color remap unit: palette store, size
// register, address counter and the three-stage distance and compare pipe.
// Depends on npr_pkg for the command and status bundles.
module npr_datapath #(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  npr_pkg::cmd_type            cmd,
   output npr_pkg::status_type         status,
   input  logic                        csr_we,
   input  logic [npr_pkg::SIZE_W-1:0]  csr_wdata,
   input  logic                        req_mode,
   input  logic [npr_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [npr_pkg::COLOR_W-1:0] req_entry_red,
   input  logic [npr_pkg::COLOR_W-1:0] req_entry_green,
   input  logic [npr_pkg::COLOR_W-1:0] req_entry_blue,
   input  logic [npr_pkg::QUERY_W-1:0] req_query_red,
   input  logic [npr_pkg::QUERY_W-1:0] req_query_green,
   input  logic [npr_pkg::QUERY_W-1:0] req_query_blue,
   input  logic [npr_pkg::INDEX_W-1:0] req_map_position,
   output logic [npr_pkg::INDEX_W-1:0] mapped_index
);

   localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int unsigned LIM_W = $clog2(PALETTE_DEPTH + 1);
   localparam int unsigned CW    = npr_pkg::COLOR_W;
   localparam int unsigned SW    = npr_pkg::SQ_W;
   localparam int unsigned DW    = npr_pkg::DIST_W;

   logic [3*CW-1:0] mem [PALETTE_DEPTH];

   logic [npr_pkg::SIZE_W-1:0] size_ff;
   logic [LIM_W-1:0]           limit;
   logic                       load_in_range;

   logic [IDX_W-1:0]  addr_ff;
   logic [CW-1:0]     q_r_ff, q_g_ff, q_b_ff;

   logic              rd_v_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [3*CW-1:0]   rd_data_ff;

   logic              sq_v_ff;
   logic [IDX_W-1:0]  sq_idx_ff;
   logic [SW-1:0]     sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SW-1:0]     sq_r_in, sq_g_in, sq_b_in;

   logic [DW-1:0]     dist_sum;
   logic [DW-1:0]     best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [npr_pkg::INDEX_W-1:0] mapped_ff;

   function automatic logic [SW-1:0] sq_abs_diff(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
      logic [CW-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SW'(d) * SW'(d);
   endfunction

   // Search limit is the size register clamped to the store depth.
   always_comb begin
      if (32'(size_ff) >= PALETTE_DEPTH) begin
         limit = LIM_W'(PALETTE_DEPTH);
      end else begin
         limit = LIM_W'(size_ff);
      end
   end

   assign load_in_range = (32'(req_entry_index) < PALETTE_DEPTH);

   assign status.is_load    = (req_mode == npr_pkg::MODE_LOAD);
   assign status.skip       = (req_map_position == '0) || (limit < LIM_W'(2));
   assign status.last_issue = (LIM_W'(addr_ff) == (limit - LIM_W'(1)));
   assign status.pipe_busy  = rd_v_ff | sq_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= npr_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   // Palette store with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && load_in_range) begin
         mem[IDX_W'(req_entry_index)] <= {req_entry_red, req_entry_green, req_entry_blue};
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff <= IDX_W'(1);
         q_r_ff  <= {req_query_red, 2'b00};
         q_g_ff  <= {req_query_green, 2'b00};
         q_b_ff  <= {req_query_blue, 2'b00};
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
      rd_idx_ff <= addr_ff;
   end

   assign sq_r_in = sq_abs_diff(q_r_ff, rd_data_ff[3*CW-1:2*CW]);
   assign sq_g_in = sq_abs_diff(q_g_ff, rd_data_ff[2*CW-1:CW]);
   assign sq_b_in = sq_abs_diff(q_b_ff, rd_data_ff[CW-1:0]);

   always_ff @(posedge clock) begin
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
      sq_idx_ff <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue;
         sq_v_ff <= rd_v_ff;
      end
   end

   assign dist_sum = DW'(sq_r_ff) + DW'(sq_g_ff) + DW'(sq_b_ff);

   // Strict less-than keeps the lower index on a tie.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (sq_v_ff && (dist_sum < best_dist_ff)) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= sq_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mapped_ff <= npr_pkg::INDEX_W'(best_idx_ff);
      end
   end

   assign mapped_index = mapped_ff;

endmodule

/* design/npr_ctrl.sv */
// Controller of the nearest palette color remap unit: the sequencing state
// machine and the result valid flag. Depends on npr_pkg for its bundles.
module npr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output npr_pkg::cmd_type    cmd,
   input  npr_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.load     = accept && status.is_load;
      cmd.start    = accept && !status.is_load;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = status.skip ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A waiting result is never overwritten by the next one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("result register overwritten while stalled");

   // An accepted remap closes the request side on the next cycle.
   a_remap_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ready)
      else $error("request accepted during a remap");

   // The result is loaded only once the distance pipe has emptied.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.pipe_busy)
      else $error("result loaded with distances in flight");

   // Reads are issued only between a start and the load of its result.
   a_issue_window: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ready && !cmd.load_out)
      else $error("palette read issued outside a search");
`endif

endmodule

/* design/nearest_palette_color_remap_unit.sv */
// Top level of the nearest palette color remap unit.
// Joins npr_ctrl and npr_datapath; uses npr_pkg, npr_req_if and npr_rsp_if.
//
//   channel   direction  width   content
//   req_bus   in         59      mode, palette entry to load, query and map position
//   rsp_bus   out        8       mapped_index, the nearest palette entry
//   csr       in         9       palette_size, written with csr_we high
//
// A load beat leaves the request side ready for the next beat.
// A remap beat searches entries 1 to limit - 1, where limit is palette_size clamped
// to PALETTE_DEPTH: one palette read per cycle from the single read port, then
// the read, square and compare pipe empties and the result is registered.
// A remap that needs no search goes straight to registering the result.
// Reset is synchronous and active high; it sets palette_size to 256 and leaves
// the palette store unwritten. A stalled result holds in its register while the
// next request beat is taken; only the next remap's result waits on it.
module nearest_palette_color_remap_unit #(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   npr_req_if.sink                     req_bus,
   npr_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [npr_pkg::SIZE_W-1:0]  csr_wdata
);

   // Command and status bundles are the only link between the two halves.
   npr_pkg::cmd_type    cmd;
   npr_pkg::status_type status;

   // The controller owns every handshake and the sequence of a search.
   npr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the palette, the size register and the distance pipe.
   npr_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_bus.mode),
      .req_entry_index  (req_bus.entry_index),
      .req_entry_red    (req_bus.entry_red),
      .req_entry_green  (req_bus.entry_green),
      .req_entry_blue   (req_bus.entry_blue),
      .req_query_red    (req_bus.query_red),
      .req_query_green  (req_bus.query_green),
      .req_query_blue   (req_bus.query_blue),
      .req_map_position (req_bus.map_position),
      .mapped_index     (rsp_bus.mapped_index)
   );

endmodule

/* tb/npr_remap_checker.sv */
`timescale 1ns / 1ps
// Result checker for the nearest palette color remap unit.
// Watches the request, result and CSR ports, predicts each mapped index and compares.
// Depends on npr_pkg, npr_req_if and npr_rsp_if.
module npr_remap_checker (
   input  logic                        clock,
   input  logic                        reset,
   npr_req_if                          req_watch,
   npr_rsp_if                          rsp_watch,
   input  logic                        csr_we,
   input  logic [npr_pkg::SIZE_W-1:0]  csr_wdata,
   output int unsigned                 mismatch_count,
   output int unsigned                 pending_count
);

   localparam int unsigned PALETTE_DEPTH = 256;
   localparam int unsigned COLOR_W       = npr_pkg::COLOR_W;
   localparam int unsigned QUERY_W       = npr_pkg::QUERY_W;
   localparam int unsigned SIZE_W        = npr_pkg::SIZE_W;
   localparam int unsigned INDEX_W       = npr_pkg::INDEX_W;

   typedef struct packed {
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
   } rgb_type;

   rgb_type            palette_copy [PALETTE_DEPTH];
   logic [SIZE_W-1:0]  size_copy;
   logic [INDEX_W-1:0] awaited_index_q [$];
   int unsigned        failures = 0;

   // Squared distance search over entries 1 to size-1; a strict compare keeps
   // the lower index on a tie.
   function automatic logic [INDEX_W-1:0] nearest_entry(
      input logic [QUERY_W-1:0] qr,
      input logic [QUERY_W-1:0] qg,
      input logic [QUERY_W-1:0] qb
   );
      int unsigned span;
      int unsigned best_i;
      int unsigned best_d;
      int unsigned d;
      int          dr;
      int          dg;
      int          db;
      span   = (size_copy > PALETTE_DEPTH) ? PALETTE_DEPTH : size_copy;
      best_i = 0;
      best_d = 32'hFFFF_FFFF;
      for (int unsigned i = 1; i < span; i++) begin
         dr = int'(qr) * 4 - int'(palette_copy[i].r);
         dg = int'(qg) * 4 - int'(palette_copy[i].g);
         db = int'(qb) * 4 - int'(palette_copy[i].b);
         d  = unsigned'(dr * dr + dg * dg + db * db);
         if (d < best_d) begin
            best_d = d;
            best_i = i;
         end
      end
      return best_i[INDEX_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [INDEX_W-1:0] want;
      if (reset) begin
         size_copy = npr_pkg::SIZE_RESET;
         awaited_index_q.delete();
      end else begin
         if (csr_we)
            size_copy = csr_wdata;
         if (req_watch.valid && req_watch.ready) begin
            if (req_watch.mode == npr_pkg::MODE_LOAD) begin
               palette_copy[req_watch.entry_index] = '{req_watch.entry_red,
                  req_watch.entry_green, req_watch.entry_blue};
            end else if (req_watch.map_position == '0) begin
               awaited_index_q.push_back('0);
            end else begin
               awaited_index_q.push_back(nearest_entry(req_watch.query_red,
                  req_watch.query_green, req_watch.query_blue));
            end
         end
         if (rsp_watch.valid && rsp_watch.ready) begin
            if (awaited_index_q.size() == 0) begin
               failures++;
               $display("%0t: mapped_index expected none, got %0d", $time,
                  rsp_watch.mapped_index);
            end else begin
               want = awaited_index_q.pop_front();
               if (rsp_watch.mapped_index !== want) begin
                  failures++;
                  $display("%0t: mapped_index expected %0d, got %0d", $time, want,
                     rsp_watch.mapped_index);
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count  <= unsigned'(awaited_index_q.size());
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the nearest palette color remap unit.
// Drives load and remap beats, the palette_size CSR and result back-pressure, and
// gives the verdict; depends on npr_pkg, both channel interfaces and npr_remap_checker.
module tb;

   localparam int unsigned COLOR_W = npr_pkg::COLOR_W;
   localparam int unsigned QUERY_W = npr_pkg::QUERY_W;
   localparam int unsigned SIZE_W  = npr_pkg::SIZE_W;
   localparam int unsigned INDEX_W = npr_pkg::INDEX_W;

   // A run that never finishes is cut off here, well past the slowest correct run.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   // Length of the one long result stall that fills the unit and blocks requests.
   localparam int unsigned LONG_HOLD   = 1500;
   // Settling time after the last result, so that a trailing load can finish.
   localparam int unsigned TAIL_CYCLES = 16;

   typedef struct packed {
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
   } shade_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;
   logic              rsp_take = 1'b0;

   npr_req_if req_ch ();
   npr_rsp_if rsp_ch ();

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   // Stimulus bookkeeping: which entries hold a color, and what that color is,
   // so that remaps never search an entry that was never loaded.
   bit          entry_loaded  [256];
   shade_type   palette_shadow [256];
   int unsigned search_span   = 256;
   int unsigned beats_sent    = 0;
   int unsigned loads_sent    = 0;
   int unsigned remaps_sent   = 0;
   int unsigned sizes_tried   = 0;
   bit          tx_calm       = 1'b0;

   // The stimulus asks for a long stall by bumping hold_asked; the receiver
   // notices the change and counts the stall out on its own.
   int unsigned hold_asked    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nearest_palette_color_remap_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   npr_remap_checker index_check (
      .clock          (clock),
      .reset          (reset),
      .req_watch      (req_ch),
      .rsp_watch      (rsp_ch),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Result side. After each accepted result the receiver draws a random stall,
   // except in calm stretches where it keeps ready high. A request for a long
   // hold overrides everything and drops ready for the LONG_HOLD stall.
   assign rsp_ch.ready = rsp_take;

   always @(posedge clock) begin
      int unsigned stall_left;
      int unsigned hold_seen;
      int unsigned results_taken;
      bit          rx_calm;
      if (reset) begin
         stall_left    = 0;
         hold_seen     = 0;
         results_taken = 0;
         rx_calm       = 1'b0;
         rsp_take     <= 1'b0;
      end else begin
         if (hold_seen != hold_asked) begin
            hold_seen  = hold_asked;
            stall_left = LONG_HOLD;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            if (results_taken % 32 == 0)
               rx_calm = ($urandom_range(0, 2) == 0);
            stall_left = rx_calm ? 0 : $urandom_range(0, 17);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_take <= (stall_left == 0);
      end
   end

   // Watchdog. Counts every cycle and ends the run if it goes on too long.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nearest_palette_color_remap_unit: mismatch");
         $finish;
      end
   end

   // Offers one request beat after a random gap and returns at the edge where
   // it is taken. valid stays high into the next beat when there is no gap.
   task automatic offer_beat(
      input logic               mode,
      input logic [INDEX_W-1:0] idx,
      input shade_type          ent,
      input logic [QUERY_W-1:0] qr,
      input logic [QUERY_W-1:0] qg,
      input logic [QUERY_W-1:0] qb,
      input logic [INDEX_W-1:0] pos
   );
      int unsigned gap;
      if (beats_sent % 40 == 0)
         tx_calm = ($urandom_range(0, 3) == 0);
      gap = tx_calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.entry_index  <= idx;
      req_ch.entry_red    <= ent.r;
      req_ch.entry_green  <= ent.g;
      req_ch.entry_blue   <= ent.b;
      req_ch.query_red    <= qr;
      req_ch.query_green  <= qg;
      req_ch.query_blue   <= qb;
      req_ch.map_position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
      if (mode == npr_pkg::MODE_LOAD) begin
         entry_loaded[idx]   = 1'b1;
         palette_shadow[idx] = ent;
         loads_sent++;
      end else begin
         remaps_sent++;
      end
   endtask

   // A load beat; the query fields are don't-care for the unit, so they carry noise.
   task automatic load_entry(input logic [INDEX_W-1:0] idx, input shade_type ent);
      offer_beat(npr_pkg::MODE_LOAD, idx, ent, QUERY_W'($urandom_range(0, 63)),
         QUERY_W'($urandom_range(0, 63)), QUERY_W'($urandom_range(0, 63)),
         INDEX_W'($urandom_range(0, 255)));
   endtask

   // A remap beat; the entry fields are ignored, so they carry noise.
   task automatic remap_color(
      input logic [QUERY_W-1:0] qr,
      input logic [QUERY_W-1:0] qg,
      input logic [QUERY_W-1:0] qb,
      input logic [INDEX_W-1:0] pos
   );
      offer_beat(npr_pkg::MODE_REMAP, INDEX_W'($urandom_range(0, 255)),
         shade_type'(24'($urandom())), qr, qg, qb, pos);
   endtask

   // Drops valid, waits for every predicted index to come back, then lets the
   // unit finish any trailing load before anything else happens.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // The palette_size register is only written while the unit sits idle.
   task automatic set_palette_size(input logic [SIZE_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      search_span = (value > 256) ? 256 : value;
      sizes_tried++;
   endtask

   // Loads every searchable entry that has never been written, so that the
   // search never touches an undefined palette word.
   task automatic fill_palette();
      for (int unsigned i = 1; i < search_span; i++)
         if (!entry_loaded[i])
            load_entry(INDEX_W'(i), shade_type'(24'($urandom())));
   endtask

   // Random palette write. Some writes copy a loaded color to build ties and
   // some pin channels to black or full scale.
   task automatic random_load();
      shade_type   ent;
      int unsigned src;
      ent = shade_type'(24'($urandom()));
      if ($urandom_range(0, 3) == 0) begin
         src = $urandom_range(1, 255);
         if (entry_loaded[src])
            ent = palette_shadow[src];
      end else if ($urandom_range(0, 7) == 0) begin
         ent.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         ent.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         ent.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      load_entry(INDEX_W'($urandom_range(0, 255)), ent);
   endtask

   // Random remap. Half the queries land on or next to a loaded entry so the
   // search has close contenders; one in eight uses map position zero.
   task automatic random_remap();
      logic [QUERY_W-1:0] qr;
      logic [QUERY_W-1:0] qg;
      logic [QUERY_W-1:0] qb;
      logic [INDEX_W-1:0] pos;
      shade_type          near;
      pos = ($urandom_range(0, 7) == 0) ? 8'd0 : INDEX_W'($urandom_range(1, 255));
      qr  = QUERY_W'($urandom_range(0, 63));
      qg  = QUERY_W'($urandom_range(0, 63));
      qb  = QUERY_W'($urandom_range(0, 63));
      if (search_span >= 2 && $urandom_range(0, 1) == 1) begin
         near = palette_shadow[$urandom_range(1, search_span - 1)];
         qr   = near.r[7:2] ^ QUERY_W'($urandom_range(0, 1));
         qg   = near.g[7:2] ^ QUERY_W'($urandom_range(0, 1));
         qb   = near.b[7:2] ^ QUERY_W'($urandom_range(0, 1));
      end
      remap_color(qr, qg, qb, pos);
   endtask

   initial begin
      logic [SIZE_W-1:0] phase_sizes [11];
      phase_sizes = '{9'd2, 9'd9, 9'd40, 9'd256, 9'd511, 9'd1, 9'd130, 9'd300, 9'd0,
                      9'd17, 9'd256};

      // Every input is known from time zero.
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.mode         = npr_pkg::MODE_LOAD;
      req_ch.entry_index  = '0;
      req_ch.entry_red    = '0;
      req_ch.entry_green  = '0;
      req_ch.entry_blue   = '0;
      req_ch.query_red    = '0;
      req_ch.query_green  = '0;
      req_ch.query_blue   = '0;
      req_ch.map_position = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Right after reset the palette is empty and the size is
      // 256, so only position-zero remaps are legal: they skip the search.
      remap_color(6'd63, 6'd63, 6'd63, 8'd0);
      remap_color(6'd0, 6'd0, 6'd0, 8'd0);
      // Entry zero is never searched; entry 255 is the top address.
      load_entry(8'd0, '{8'hFF, 8'hFF, 8'hFF});
      load_entry(8'd255, '{8'h00, 8'h00, 8'h00});

      // With fewer than two entries in use nothing is searched and the answer is zero.
      set_palette_size(9'd0);
      remap_color(6'd63, 6'd63, 6'd63, 8'd255);
      remap_color(6'd0, 6'd0, 6'd0, 8'd1);
      set_palette_size(9'd1);
      remap_color(6'd32, 6'd0, 6'd63, 8'd128);

      // Four entries with a tie between entries two and three: the lower wins.
      set_palette_size(9'd4);
      load_entry(8'd1, '{8'h00, 8'h00, 8'h00});
      load_entry(8'd2, '{8'd252, 8'd252, 8'd252});
      load_entry(8'd3, '{8'd252, 8'd252, 8'd252});
      remap_color(6'd63, 6'd63, 6'd63, 8'd255);
      remap_color(6'd0, 6'd0, 6'd0, 8'd1);
      remap_color(6'd32, 6'd32, 6'd32, 8'd7);
      // An exact hit on entry one, then position zero against a live palette.
      load_entry(8'd1, '{8'd128, 8'd128, 8'd128});
      remap_color(6'd32, 6'd32, 6'd32, 8'd200);
      remap_color(6'd63, 6'd63, 6'd63, 8'd0);
      set_palette_size(9'd3);
      remap_color(6'd63, 6'd63, 6'd63, 8'd9);

      // Back-pressure. The receiver holds off for a long stretch while a run of
      // quick remaps keeps coming, so the result register fills and the
      // request side has to stall.
      set_palette_size(9'd9);
      fill_palette();
      hold_asked <= hold_asked + 1;
      repeat (12) random_remap();

      // Random phases, each under its own palette_size, from empty through the
      // full depth to values past it that must act as the full depth.
      foreach (phase_sizes[p]) begin
         set_palette_size(phase_sizes[p]);
         fill_palette();
         repeat (50) begin
            if ($urandom_range(0, 99) < 65)
               random_remap();
            else
               random_load();
         end
      end

      settle();
      $display("Covered %0d palette loads and %0d remaps over %0d palette_size settings,",
         loads_sent, remaps_sent, sizes_tried);
      $display("with random gaps on both channels and one long result stall.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("nearest_palette_color_remap_unit: match");
      end else begin
         $display("nearest_palette_color_remap_unit: mismatch");
      end
      $finish;
   end

endmodule
